// ===== rtl/lhu_pkg.sv =====
`default_nettype none

package lhu_pkg;

    // Histogram geometry.
    localparam int BUCKETS     = 42;
    localparam int LAST_BUCKET = BUCKETS - 1;
    localparam int IDX_W       = $clog2(BUCKETS);
    localparam int USED_W      = $clog2(BUCKETS + 1);

    // Fixed field widths of the ports.
    localparam int CMD_W    = 2;
    localparam int SAMPLE_W = 64;
    localparam int COUNT_W  = 64;
    localparam int SEL_W    = 6;
    localparam int USED_O_W = 6;

    // Width that holds a bit position of a sample plus one, and any bucket count.
    localparam int POS_W = $clog2(SAMPLE_W + 1);

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/lhu_ram.sv =====
`default_nettype none

module lhu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 42
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/log2_latency_histogram_unit.sv =====
// Sequence: a taken command moves the sequencer from S_IDLE to S_EXEC, and its
// result is registered as it leaves S_EXEC; a stalled output holds it in S_EXEC.
// Commands are taken one at a time: in_stall stays high until the last one
// leaves S_EXEC after its counter RAM read and write-back; a clear does the same.
// Reset is asynchronous and active low; it empties every bucket at once
// through per-bucket valid flops, so no clearing pass follows reset.
`default_nettype none

module log2_latency_histogram_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [lhu_pkg::CMD_W-1:0]     cmd,
    input  wire logic [lhu_pkg::SAMPLE_W-1:0]  sample_ns,
    input  wire logic [lhu_pkg::SEL_W-1:0]     bucket_index,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [lhu_pkg::COUNT_W-1:0]   bucket_count,
    output logic      [lhu_pkg::USED_O_W-1:0]  used_buckets
);

    import lhu_pkg::*;

    state_t                state_reg, state_next;
    logic [CMD_W-1:0]      cmd_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  in_range_reg;
    logic [BUCKETS-1:0]    valid_reg, valid_next;
    logic [USED_W-1:0]     highest_used_reg, highest_used_next;
    logic                  out_valid_reg;
    logic [COUNT_W-1:0]    bucket_count_reg, bucket_count_next;
    logic [USED_O_W-1:0]   used_buckets_reg;

    logic                  accept;
    logic                  complete;
    logic [SAMPLE_W-1:0]   ns_minus_one;
    logic [POS_W-1:0]      ceil_pos;
    logic [IDX_W-1:0]      pick_idx;
    logic [IDX_W-1:0]      ram_raddr;
    logic                  sel_in_range;
    logic [COUNT_W-1:0]    ram_rdata;
    logic [COUNT_W-1:0]    cur_count;
    logic [COUNT_W-1:0]    inc_count;
    logic                  ram_we;
    logic [USED_W-1:0]     add_used;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    // The command finishes once the output register is free or being emptied.
    assign complete = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);

    // Bucket pick: ceil(log2(ns)) from the top set bit of ns - 1, capped.
    assign ns_minus_one = sample_ns - SAMPLE_W'(1);

    always_comb
    begin
        ceil_pos = '0;
        for (int i = 0; i < SAMPLE_W; i++)
        begin
            if (ns_minus_one[i])
            begin
                ceil_pos = POS_W'(i + 1);
            end
        end
        if (sample_ns <= SAMPLE_W'(1))
        begin
            ceil_pos = '0;
        end
        if (ceil_pos > POS_W'(LAST_BUCKET))
        begin
            pick_idx = IDX_W'(LAST_BUCKET);
        end
        else
        begin
            pick_idx = IDX_W'(ceil_pos);
        end
    end

    // Reads past the last bucket return zero.
    assign sel_in_range = ({1'b0, bucket_index} < (SEL_W + 1)'(BUCKETS));
    assign ram_raddr    = (cmd == CMD_READ) ? IDX_W'(bucket_index) : pick_idx;

    // Capture the command on its transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= cmd;
            idx_reg      <= ram_raddr;
            in_range_reg <= sel_in_range;
        end
    end

    lhu_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (BUCKETS)
    ) u_counters (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (inc_count),
        .re    (accept),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A bucket whose valid flop is clear holds zero.
    assign cur_count = valid_reg[idx_reg] ? ram_rdata : '0;
    assign inc_count = (&cur_count) ? cur_count : cur_count + COUNT_W'(1);
    assign add_used  = USED_W'(idx_reg) + USED_W'(1);

    // Execute the captured command.
    always_comb
    begin
        ram_we            = 1'b0;
        valid_next        = valid_reg;
        highest_used_next = highest_used_reg;
        bucket_count_next = '0;
        case (cmd_reg)
            CMD_ADD:
            begin
                ram_we              = complete;
                valid_next[idx_reg] = 1'b1;
                if (add_used > highest_used_reg)
                begin
                    highest_used_next = add_used;
                end
            end
            CMD_CLEAR:
            begin
                valid_next        = '0;
                highest_used_next = '0;
            end
            CMD_READ:
            begin
                if (in_range_reg)
                begin
                    bucket_count_next = cur_count;
                end
            end
            default:
            begin
                bucket_count_next = '0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (complete)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            valid_reg        <= '0;
            highest_used_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (complete)
            begin
                valid_reg        <= valid_next;
                highest_used_reg <= highest_used_next;
                out_valid_reg    <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (complete)
        begin
            bucket_count_reg <= bucket_count_next;
            used_buckets_reg <= USED_O_W'(highest_used_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign bucket_count = bucket_count_reg;
    assign used_buckets = used_buckets_reg;

    // The used count never passes the number of buckets.
    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        highest_used_reg <= USED_W'(BUCKETS))
        else $error("used bucket count out of range");

    // Only an add writes the counter RAM, and only as it completes.
    a_we_add_only: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_EXEC) && (cmd_reg == CMD_ADD) && complete)
        else $error("counter write outside an add");

    // A completed clear leaves every bucket empty.
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (complete && (cmd_reg == CMD_CLEAR)) |=>
            (valid_reg == '0) && (highest_used_reg == '0))
        else $error("clear left buckets in use");

    // A completed add marks its bucket in use.
    a_add_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (complete && (cmd_reg == CMD_ADD)) |=> valid_reg[$past(idx_reg)])
        else $error("add did not mark its bucket");

    // Each transfer in is followed by the sequencer entering S_EXEC.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted command not executed");

endmodule

`default_nettype wire

// ===== tb/tb_log2_latency_histogram_unit.sv =====
`timescale 1ns / 1ps

module tb_log2_latency_histogram_unit;

    import lhu_pkg::*;

    // The block has no code of its own for the fourth command value.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 750;
    localparam int STALL_LIMIT  = 5000;
    localparam int LONG_HOLD    = 150;
    localparam int HOLD_AFTER   = 200;
    localparam int TAIL_CYCLES  = 10;
    localparam int MAX_REPORTS  = 40;

    typedef struct {
        logic [COUNT_W-1:0]  count;
        logic [USED_O_W-1:0] used;
    } hist_result_t;

    typedef struct {
        logic [CMD_W-1:0]    op;
        logic [SAMPLE_W-1:0] ns;
        logic [SEL_W-1:0]    sel;
        bit                  typed;
        logic [COUNT_W-1:0]  count;
        logic [USED_O_W-1:0] used;
    } plan_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [CMD_W-1:0]    cmd;
    logic [SAMPLE_W-1:0] sample_ns;
    logic [SEL_W-1:0]    bucket_index;
    logic                out_valid;
    logic                out_stall;
    logic [COUNT_W-1:0]  bucket_count;
    logic [USED_O_W-1:0] used_buckets;

    // Hand-typed result for the current directed row, read by the monitor.
    bit                  row_typed;
    logic [COUNT_W-1:0]  row_count;
    logic [USED_O_W-1:0] row_used;

    // Shadow copy of the histogram.
    logic [COUNT_W-1:0]  shadow_bins [BUCKETS];
    logic [6:0]          shadow_used;

    hist_result_t        pending_results [$];
    plan_row_t           directed_plan [$];

    int errors;
    int results_checked;
    int n_add, n_read, n_read_oob, n_clear, n_unused;
    int peak_used;
    int tx_mode;
    bit rx_hold;
    bit hold_done;

    log2_latency_histogram_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .sample_ns    (sample_ns),
        .bucket_index (bucket_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .bucket_count (bucket_count),
        .used_buckets (used_buckets)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Smallest bucket whose power of two covers the sample, capped at the last one.
    function automatic int bucket_for(logic [SAMPLE_W-1:0] ns);
        for (int b = 0; b < LAST_BUCKET; b++)
        begin
            if ((64'd1 << b) >= ns)
                return b;
        end
        return LAST_BUCKET;
    endfunction

    // Applies one command to the shadow histogram and returns the result it yields.
    function automatic hist_result_t histogram_update(logic [CMD_W-1:0] op,
                                                      logic [SAMPLE_W-1:0] ns,
                                                      logic [SEL_W-1:0] sel);
        hist_result_t r;
        int b;
        r.count = '0;
        case (op)
            CMD_ADD:
            begin
                b = bucket_for(ns);
                if (shadow_bins[b] != '1)
                    shadow_bins[b] = shadow_bins[b] + 1'b1;
                if (b + 1 > shadow_used)
                    shadow_used = 7'(b + 1);
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < BUCKETS; i++)
                    shadow_bins[i] = '0;
                shadow_used = '0;
            end
            CMD_READ:
            begin
                if (sel < BUCKETS)
                    r.count = shadow_bins[sel];
            end
            default:
            begin
            end
        endcase
        r.used = shadow_used[USED_O_W-1:0];
        return r;
    endfunction

    function automatic int next_gap();
        int r;
        if (rx_hold || tx_mode == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (tx_mode == 1)
            return (r < 30) ? $urandom_range(1, 3) : 0;
        if (r < 8)
            return $urandom_range(10, 40);
        return $urandom_range(0, 4);
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        int unsigned k;
        k = $urandom_range(0, SAMPLE_W - 1);
        case ($urandom_range(0, 3))
            0: return {$urandom, $urandom};
            1: return {$urandom, $urandom} >> $urandom_range(0, SAMPLE_W - 1);
            2: return (64'd1 << k) + $urandom_range(0, 2) - 1;
            default: return SAMPLE_W'($urandom_range(0, 16));
        endcase
    endfunction

    task automatic add_row(logic [CMD_W-1:0] op, logic [SAMPLE_W-1:0] ns,
                           logic [SEL_W-1:0] sel, bit typed,
                           logic [COUNT_W-1:0] count, logic [USED_O_W-1:0] used);
        plan_row_t row;
        row.op    = op;
        row.ns    = ns;
        row.sel   = sel;
        row.typed = typed;
        row.count = count;
        row.used  = used;
        directed_plan.push_back(row);
    endtask

    // Offers one command and returns at the edge where it is transferred.
    task automatic send_command(plan_row_t row);
        int gap;
        gap = next_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= row.op;
        sample_ns    <= row.ns;
        bucket_index <= row.sel;
        row_typed    <= row.typed;
        row_count    <= row.count;
        row_used     <= row.used;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stops offering and waits for every outstanding result.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic flag_error(string what, logic [63:0] expected, logic [63:0] actual);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, what, expected, actual);
    endtask

    // Checks each result transfer, then predicts each command transfer.
    always @(posedge clk)
    begin
        hist_result_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display({"%0t: unexpected result: expected none, ",
                                  "actual count %0d used %0d"},
                                 $time, bucket_count, used_buckets);
                end
                else
                begin
                    e = pending_results.pop_front();
                    if (bucket_count !== e.count)
                        flag_error("bucket_count", e.count, bucket_count);
                    if (used_buckets !== e.used)
                        flag_error("used_buckets", e.used, used_buckets);
                end
            end
            if (in_valid && !in_stall)
            begin
                e = histogram_update(cmd, sample_ns, bucket_index);
                if (row_typed)
                begin
                    e.count = row_count;
                    e.used  = row_used;
                end
                pending_results.push_back(e);
                if (shadow_used > peak_used)
                    peak_used = shadow_used;
                case (cmd)
                    CMD_ADD:   n_add++;
                    CMD_CLEAR: n_clear++;
                    CMD_READ:
                    begin
                        n_read++;
                        if (bucket_index >= BUCKETS)
                            n_read_oob++;
                    end
                    default:   n_unused++;
                endcase
            end
        end
    end

    // Receiver: runs of random stall density, plus one long hold-off.
    initial
    begin
        int run_len;
        int pct;
        @(posedge rst_n);
        forever
        begin
            if (!hold_done && results_checked >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                rx_hold   = 1'b1;
                repeat (LONG_HOLD)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
                rx_hold = 1'b0;
            end
            run_len = $urandom_range(5, 40);
            case ($urandom_range(0, 4))
                0: pct = 0;
                1: pct = 20;
                2: pct = 50;
                3: pct = 80;
                default: pct = ($urandom_range(0, 3) == 0) ? 100 : 10;
            endcase
            repeat (run_len)
            begin
                @(negedge clk);
                out_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    // Ends the run if no transfer happens on either side for too long.
    initial
    begin
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Stimulus and end of run.
    initial
    begin
        plan_row_t row;
        int r;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cmd          = CMD_ADD;
        sample_ns    = '0;
        bucket_index = '0;
        out_stall    = 1'b0;
        row_typed    = 1'b0;
        row_count    = '0;
        row_used     = '0;
        errors       = 0;
        tx_mode      = 1;
        for (int i = 0; i < BUCKETS; i++)
            shadow_bins[i] = '0;
        shadow_used = '0;

        // Empty histogram, then the smallest and largest samples.
        add_row(CMD_READ,   '1,                    6'd0,  1, 64'd0, 6'd0);
        add_row(CMD_READ,   '0,                    6'd41, 1, 64'd0, 6'd0);
        add_row(CMD_READ,   '0,                    6'd63, 1, 64'd0, 6'd0);
        add_row(CMD_UNUSED, '1,                    6'd63, 1, 64'd0, 6'd0);
        add_row(CMD_ADD,    64'd0,                 6'd0,  1, 64'd0, 6'd1);
        add_row(CMD_ADD,    64'd1,                 6'd63, 1, 64'd0, 6'd1);
        add_row(CMD_READ,   '0,                    6'd0,  1, 64'd2, 6'd1);
        add_row(CMD_ADD,    64'd2,                 6'd0,  0, 64'd0, 6'd0);
        add_row(CMD_ADD,    64'd3,                 6'd0,  0, 64'd0, 6'd0);
        add_row(CMD_ADD,    64'd1 << 40,           6'd0,  1, 64'd0, 6'd41);
        add_row(CMD_ADD,    (64'd1 << 40) + 1,     6'd0,  1, 64'd0, 6'd42);
        add_row(CMD_ADD,    '1,                    6'd0,  1, 64'd0, 6'd42);
        add_row(CMD_READ,   '0,                    6'd41, 1, 64'd2, 6'd42);
        add_row(CMD_READ,   '0,                    6'd40, 0, 64'd0, 6'd0);
        // Reads past the last bucket return zero and change nothing.
        add_row(CMD_READ,   '1,                    6'd42, 1, 64'd0, 6'd42);
        add_row(CMD_READ,   '0,                    6'd63, 1, 64'd0, 6'd42);
        add_row(CMD_UNUSED, 64'h5555555555555555,  6'd21, 1, 64'd0, 6'd42);
        add_row(CMD_CLEAR,  '1,                    6'd63, 1, 64'd0, 6'd0);
        add_row(CMD_READ,   '0,                    6'd41, 1, 64'd0, 6'd0);
        add_row(CMD_ADD,    64'd1 << 63,           6'd42, 1, 64'd0, 6'd42);
        add_row(CMD_ADD,    64'h5555555555555555,  6'd21, 0, 64'd0, 6'd0);
        add_row(CMD_ADD,    64'hAAAAAAAAAAAAAAAA,  6'd42, 0, 64'd0, 6'd0);
        add_row(CMD_ADD,    64'd5,                 6'd0,  0, 64'd0, 6'd0);
        add_row(CMD_READ,   '0,                    6'd3,  0, 64'd0, 6'd0);
        add_row(CMD_CLEAR,  '0,                    6'd0,  1, 64'd0, 6'd0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_plan[i])
            send_command(directed_plan[i]);
        drain();

        // Random commands: mostly adds and reads, with occasional clears and unused codes.
        row.typed = 1'b0;
        row.count = '0;
        row.used  = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
                tx_mode = $urandom_range(0, 2);
            if (n == RANDOM_ITEMS / 2)
                drain();
            r = $urandom_range(0, 99);
            if (r < 58)
                row.op = CMD_ADD;
            else if (r < 92)
                row.op = CMD_READ;
            else if (r < 95)
                row.op = CMD_CLEAR;
            else
                row.op = CMD_UNUSED;
            row.ns  = random_sample();
            row.sel = SEL_W'(($urandom_range(0, 4) == 0) ? $urandom_range(BUCKETS, 63)
                                                         : $urandom_range(0, LAST_BUCKET));
            send_command(row);
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (pending_results.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time,
                     pending_results.size());
        end
        $display({"Commands sent: %0d add, %0d read (%0d past the last bucket), ",
                  "%0d clear, %0d unused."},
                 n_add, n_read, n_read_oob, n_clear, n_unused);
        $display("Results checked: %0d; highest bucket use seen: %0d of %0d.",
                 results_checked, peak_used, BUCKETS);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
